// File: sv/rbad_pkg.sv
package rbad_pkg;

    localparam int RBAD_WINDOW = 32;

    localparam int SAMPLE_W = 12;
    localparam int SQUARE_W = 2 * SAMPLE_W;
    localparam int QUOT_W   = 32;
    localparam int ROOT_W   = 16;
    localparam int Q4_W     = 16;
    localparam int SCORE_W  = 16;
    localparam int TOTAL_W  = 32;
    localparam int ACC_W    = 32;

    localparam int ALPHA_W    = 17;
    localparam int SCALE_W    = 16;
    localparam int THRESH_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam int MUL_X_W = 32;
    localparam int MUL_Y_W = 17;

    localparam logic [ALPHA_W-1:0]  ALPHA_ONE  = 17'h10000;
    localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 17'd3277;
    localparam logic [SCALE_W-1:0]  SCALE_RST  = 16'd33800;
    localparam logic [THRESH_W-1:0] THRESH_RST = 16'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA  = 2'd0,
        CFG_SCALE  = 2'd1,
        CFG_THRESH = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQR,
        ST_DIV,
        ST_SQRT,
        ST_MIX,
        ST_DELTA,
        ST_SCORE,
        ST_OUT
    } t_state;

endpackage

// File: sv/rbad_if.sv
interface rbad_in_if;
    logic                          valid;
    logic                          ready;
    logic [rbad_pkg::SAMPLE_W-1:0] adc_sample;
    logic                          obstacle;

    modport source (output valid, adc_sample, obstacle, input ready);
    modport sink   (input valid, adc_sample, obstacle, output ready);
endinterface

interface rbad_out_if;
    logic                         valid;
    logic                         ready;
    logic [rbad_pkg::Q4_W-1:0]    rms_q4;
    logic [rbad_pkg::Q4_W-1:0]    baseline_q4;
    logic [rbad_pkg::SCORE_W-1:0] score_q8;
    logic                         anomaly;
    logic [rbad_pkg::TOTAL_W-1:0] anomaly_total;

    modport source (output valid, rms_q4, baseline_q4, score_q8, anomaly, anomaly_total,
                    input ready);
    modport sink   (input valid, rms_q4, baseline_q4, score_q8, anomaly, anomaly_total,
                    output ready);
endinterface

interface rbad_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rbad_pkg::CFG_IDX_W-1:0]  index;
    logic [rbad_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/rbad_div.sv
module rbad_div #(
    parameter int WINDOW = rbad_pkg::RBAD_WINDOW,
    parameter int SUM_W  = rbad_pkg::SQUARE_W + $clog2(rbad_pkg::RBAD_WINDOW)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [SUM_W-1:0]            i_sum,
    output logic                        o_done,
    output logic [rbad_pkg::QUOT_W-1:0] o_quot
);

    localparam int DVD_W = SUM_W + 8;
    localparam int RW    = $clog2(WINDOW);
    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_q;
    logic [RW-1:0]    r_rem;
    logic [RW:0]      trial;
    logic             ge;
    logic [RW-1:0]    n_rem;

    // restoring division by the window length, one quotient bit per cycle
    always_comb begin
        trial = {r_rem, r_q[DVD_W-1]};
        ge    = trial >= (RW+1)'(WINDOW);
        n_rem = ge ? RW'(trial - (RW+1)'(WINDOW)) : trial[RW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= {i_sum, 8'b0};
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[DVD_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q[rbad_pkg::QUOT_W-1:0];

endmodule

// File: sv/rbad_sqrt.sv
module rbad_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rbad_pkg::QUOT_W-1:0] i_rad,
    output logic                        o_done,
    output logic [rbad_pkg::ROOT_W-1:0] o_root
);

    localparam int RAD_W = rbad_pkg::QUOT_W;
    localparam int RT_W  = rbad_pkg::ROOT_W;
    localparam int REM_W = RT_W + 2;
    localparam int CNT_W = $clog2(RT_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [RAD_W-1:0] r_rad;
    logic [RT_W-1:0]  r_root;
    logic [REM_W-1:0] r_rem;
    logic [REM_W+1:0] rem_t;
    logic [REM_W+1:0] trial;
    logic             ge;

    // two radicand bits per cycle, one root bit
    always_comb begin
        rem_t = {r_rem, r_rad[RAD_W-1:RAD_W-2]};
        trial = {2'b00, r_root, 2'b01};
        ge    = rem_t >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(RT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_root <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_root <= {r_root[RT_W-2:0], ge};
            r_rem  <= ge ? REM_W'(rem_t - trial) : rem_t[REM_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: sv/rbad_mul.sv
module rbad_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rbad_pkg::MUL_X_W-1:0] i_x1,
    input  logic [rbad_pkg::MUL_Y_W-1:0] i_y1,
    input  logic [rbad_pkg::MUL_X_W-1:0] i_x2,
    input  logic [rbad_pkg::MUL_Y_W-1:0] i_y2,
    output logic                         o_done,
    output logic [rbad_pkg::MUL_X_W-1:0] o_prod_hi
);

    localparam int XW    = rbad_pkg::MUL_X_W;
    localparam int YW    = rbad_pkg::MUL_Y_W;
    localparam int HW    = XW + 1;
    localparam int SW    = XW + 2;
    localparam int CNT_W = $clog2(YW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [XW-1:0]    r_x1;
    logic [XW-1:0]    r_x2;
    logic [YW-1:0]    r_y1;
    logic [YW-1:0]    r_y2;
    logic [HW-1:0]    r_hi;
    logic [XW-1:0]    r_res;
    logic [SW-1:0]    step_sum;

    // x1*y1 + x2*y2, multiplier bits lsb first, keeps the product from bit YW-1 up
    always_comb begin
        step_sum = SW'(r_hi)
                 + (r_y1[0] ? SW'(r_x1) : '0)
                 + (r_y2[0] ? SW'(r_x2) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(YW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x1 <= i_x1;
            r_x2 <= i_x2;
            r_y1 <= i_y1;
            r_y2 <= i_y2;
            r_hi <= '0;
        end else if (r_busy) begin
            r_y1  <= {1'b0, r_y1[YW-1:1]};
            r_y2  <= {1'b0, r_y2[YW-1:1]};
            r_hi  <= step_sum[SW-1:1];
            r_res <= step_sum[XW-1:0];
        end
    end

    assign o_done    = r_done;
    assign o_prod_hi = r_res;

endmodule

// File: sv/rms_baseline_anomaly_detector.sv
// channel   dir  modport  payload
// i_in      in   sink     adc_sample[11:0], obstacle
// o_out     out  source   rms_q4, baseline_q4, score_q8, anomaly, anomaly_total[31:0]
// i_cfg     in   sink     index[1:0], data[16:0]; ready always high
//
// a sample is accepted, then squared bit-serially into the sum
// the window's last sample adds the serial divider, the root, the baseline
// multiply-add (skipped on the first window), the delta and score multiply and
// the output load
// synchronous active-low reset clears the window, the baseline and the anomaly count
// a result waits in the output register; the next sample is taken meanwhile and only
// the next window close stalls on an untaken result
module rms_baseline_anomaly_detector #(
    parameter int WINDOW = rbad_pkg::RBAD_WINDOW
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rbad_in_if.sink     i_in,
    rbad_out_if.source  o_out,
    rbad_cfg_if.sink    i_cfg
);

    localparam int SUM_W = rbad_pkg::SQUARE_W + $clog2(WINDOW);
    localparam int IDX_W = $clog2(WINDOW);
    localparam int SW    = rbad_pkg::SAMPLE_W;
    localparam int SQ_W  = rbad_pkg::SQUARE_W;
    localparam int SC_W  = $clog2(SW);
    localparam int XW    = rbad_pkg::MUL_X_W;
    localparam int YW    = rbad_pkg::MUL_Y_W;

    rbad_pkg::t_state r_state;
    rbad_pkg::t_state n_state;

    logic [rbad_pkg::ALPHA_W-1:0]  r_alpha;
    logic [rbad_pkg::SCALE_W-1:0]  r_scale;
    logic [rbad_pkg::THRESH_W-1:0] r_thresh;

    logic [IDX_W-1:0]             r_idx;
    logic                         r_close;
    logic                         r_obst;
    logic [SC_W-1:0]              r_sq_cnt;
    logic [SQ_W-1:0]              r_mcand;
    logic [SW-1:0]                r_mq;
    logic [SUM_W-1:0]             r_sum;
    logic [SUM_W-1:0]             n_sum;
    logic [rbad_pkg::ROOT_W-1:0]  r_rms;
    logic [rbad_pkg::ACC_W-1:0]   r_base;
    logic                         r_base_valid;
    logic [rbad_pkg::SCORE_W-1:0] r_score;
    logic                         r_anom;
    logic [rbad_pkg::TOTAL_W-1:0] r_total;
    logic                         r_out_valid;

    logic                          sq_last;
    logic                          div_start;
    logic                          div_done;
    logic [rbad_pkg::QUOT_W-1:0]   quot;
    logic                          sqrt_done;
    logic [rbad_pkg::ROOT_W-1:0]   root;
    logic                          mul_start;
    logic                          mul_done;
    logic [XW-1:0]                 mul_res;
    logic [XW-1:0]                 mul_x1;
    logic [YW-1:0]                 mul_y1;
    logic [XW-1:0]                 mul_x2;
    logic [YW-1:0]                 mul_y2;
    logic                          out_load;
    logic [rbad_pkg::ALPHA_W-1:0]  alpha_sat;
    logic [rbad_pkg::ALPHA_W-1:0]  keep_w;
    logic [rbad_pkg::Q4_W-1:0]     base_q4;
    logic [rbad_pkg::Q4_W-1:0]     delta;
    logic [rbad_pkg::SCORE_W-1:0]  score_w;
    logic                          anom_w;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= rbad_pkg::ALPHA_RST;
            r_scale  <= rbad_pkg::SCALE_RST;
            r_thresh <= rbad_pkg::THRESH_RST;
        end else if (i_cfg.valid) begin
            unique case (rbad_pkg::t_cfg_idx'(i_cfg.index))
                rbad_pkg::CFG_ALPHA: begin
                    r_alpha <= i_cfg.data[rbad_pkg::ALPHA_W-1:0];
                end
                rbad_pkg::CFG_SCALE: begin
                    r_scale <= i_cfg.data[rbad_pkg::SCALE_W-1:0];
                end
                rbad_pkg::CFG_THRESH: begin
                    r_thresh <= i_cfg.data[rbad_pkg::THRESH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        sq_last   = r_sq_cnt == SC_W'(SW - 1);
        n_sum     = r_sum + (r_mq[0] ? SUM_W'(r_mcand) : '0);
        alpha_sat = (r_alpha > rbad_pkg::ALPHA_ONE) ? rbad_pkg::ALPHA_ONE : r_alpha;
        keep_w    = rbad_pkg::ALPHA_ONE - alpha_sat;
        base_q4   = r_base[rbad_pkg::ACC_W-1:rbad_pkg::ACC_W-rbad_pkg::Q4_W];
        delta     = (r_rms >= base_q4) ? r_rms - base_q4 : base_q4 - r_rms;
        score_w   = mul_res[rbad_pkg::SCORE_W-1:0];
        anom_w    = (score_w >= r_thresh) || r_obst;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rbad_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = rbad_pkg::ST_SQR;
                end
            end
            rbad_pkg::ST_SQR: begin
                if (sq_last) begin
                    n_state = r_close ? rbad_pkg::ST_DIV : rbad_pkg::ST_IDLE;
                end
            end
            rbad_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = rbad_pkg::ST_SQRT;
                end
            end
            rbad_pkg::ST_SQRT: begin
                if (sqrt_done) begin
                    n_state = r_base_valid ? rbad_pkg::ST_MIX : rbad_pkg::ST_DELTA;
                end
            end
            rbad_pkg::ST_MIX: begin
                if (mul_done) begin
                    n_state = rbad_pkg::ST_DELTA;
                end
            end
            rbad_pkg::ST_DELTA: begin
                n_state = rbad_pkg::ST_SCORE;
            end
            rbad_pkg::ST_SCORE: begin
                if (mul_done) begin
                    n_state = rbad_pkg::ST_OUT;
                end
            end
            rbad_pkg::ST_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = rbad_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rbad_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        i_in.ready = r_state == rbad_pkg::ST_IDLE;
        div_start  = (r_state == rbad_pkg::ST_SQR) && sq_last && r_close;
        mul_start  = ((r_state == rbad_pkg::ST_SQRT) && sqrt_done && r_base_valid)
                   || (r_state == rbad_pkg::ST_DELTA);
        out_load   = (r_state == rbad_pkg::ST_OUT) && (!r_out_valid || o_out.ready);
        if (r_state == rbad_pkg::ST_DELTA) begin
            mul_x1 = XW'(delta);
            mul_y1 = YW'(r_scale);
            mul_x2 = '0;
            mul_y2 = '0;
        end else begin
            mul_x1 = r_base;
            mul_y1 = keep_w;
            mul_x2 = {root, 16'b0};
            mul_y2 = alpha_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rbad_pkg::ST_IDLE;
            r_idx        <= '0;
            r_close      <= 1'b0;
            r_sq_cnt     <= '0;
            r_sum        <= '0;
            r_base       <= '0;
            r_base_valid <= 1'b0;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_in.valid && i_in.ready) begin
                r_sq_cnt <= '0;
                if (r_idx == IDX_W'(WINDOW - 1)) begin
                    r_idx   <= '0;
                    r_close <= 1'b1;
                end else begin
                    r_idx   <= r_idx + 1'b1;
                    r_close <= 1'b0;
                end
            end
            if (r_state == rbad_pkg::ST_SQR) begin
                r_sq_cnt <= r_sq_cnt + 1'b1;
                r_sum    <= div_start ? '0 : n_sum;
            end
            if ((r_state == rbad_pkg::ST_SQRT) && sqrt_done && !r_base_valid) begin
                r_base       <= {root, 16'b0};
                r_base_valid <= 1'b1;
            end
            if ((r_state == rbad_pkg::ST_MIX) && mul_done) begin
                r_base <= mul_res;
            end
            if ((r_state == rbad_pkg::ST_SCORE) && mul_done && anom_w) begin
                r_total <= r_total + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_mcand <= SQ_W'(i_in.adc_sample);
            r_mq    <= i_in.adc_sample;
            r_obst  <= i_in.obstacle;
        end else if (r_state == rbad_pkg::ST_SQR) begin
            r_mcand <= {r_mcand[SQ_W-2:0], 1'b0};
            r_mq    <= {1'b0, r_mq[SW-1:1]};
        end
        if ((r_state == rbad_pkg::ST_SQRT) && sqrt_done) begin
            r_rms <= root;
        end
        if ((r_state == rbad_pkg::ST_SCORE) && mul_done) begin
            r_score <= score_w;
            r_anom  <= anom_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_out.rms_q4        <= r_rms;
            o_out.baseline_q4   <= base_q4;
            o_out.score_q8      <= r_score;
            o_out.anomaly       <= r_anom;
            o_out.anomaly_total <= r_total;
        end
    end

    assign o_out.valid = r_out_valid;

    rbad_div #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (n_sum),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    rbad_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_done),
        .i_rad   (quot),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    rbad_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_x1      (mul_x1),
        .i_y1      (mul_y1),
        .i_x2      (mul_x2),
        .i_y2      (mul_y2),
        .o_done    (mul_done),
        .o_prod_hi (mul_res)
    );

endmodule
